@@ rtl/pose_frame_parser_assert.svh @@
// Assertion macros used by the checker file pfp_checker.sv.
`ifndef POSE_FRAME_PARSER_ASSERT_SVH
`define POSE_FRAME_PARSER_ASSERT_SVH

// Property must hold in the same cycle.
`define PFP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Property must hold in the next cycle.
`define PFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/pfp_pkg.sv @@
// ----------------------------------------------------------------------------
// pfp_pkg
// Constants, types and helpers for the pose frame parser.
// ----------------------------------------------------------------------------
package pfp_pkg;

   localparam logic [7:0] HDR_FIRST  = 8'h0D;
   localparam logic [7:0] HDR_SECOND = 8'h0A;
   localparam logic [7:0] FTR_FIRST  = 8'h0A;
   localparam logic [7:0] FTR_SECOND = 8'h0D;

   localparam logic [4:0] PH_HUNT     = 5'd0;
   localparam logic [4:0] PH_HDR2     = 5'd1;
   localparam logic [4:0] PH_PAY_FIRST = 5'd2;
   localparam logic [4:0] PH_PAY_LAST = 5'd25;
   localparam logic [4:0] PH_FTR1     = 5'd26;
   localparam logic [4:0] PH_FTR2     = 5'd27;

   localparam logic [2:0] WORD_YAW = 3'd0;
   localparam logic [2:0] WORD_X   = 3'd3;
   localparam logic [2:0] WORD_Y   = 3'd4;

   localparam logic CSR_OFFSET_X = 1'b0;
   localparam logic CSR_OFFSET_Y = 1'b1;

   typedef struct packed {
      logic        done;
      logic [31:0] yaw;
      logic [31:0] x;
      logic [31:0] y;
   } frame_type;

   // leading zeros of a 27-bit significand, 27 when zero
   function automatic logic [4:0] lzc27(input logic [26:0] v);
      logic [4:0] cnt;
      cnt = 5'd27;
      for (int i = 0; i < 27; i++) begin
         if (v[i]) cnt = 5'(26 - i);
      end
      return cnt;
   endfunction

endpackage

@@ rtl/pose_frame_parser.sv @@
// ----------------------------------------------------------------------------
// pose_frame_parser
// Deframes encoder bytes and emits yaw and offset-corrected x, y per frame.
// ----------------------------------------------------------------------------
// channel | dir | handshake            | payload
// req     | in  | req_valid/req_ready  | req_rx_byte
// rsp     | out | rsp_valid/rsp_ready  | rsp_yaw_bits, rsp_pos_x_bits, rsp_pos_y_bits
// csr     | in  | csr_valid/csr_ready  | csr_index, csr_data
//
// One byte is taken every cycle while the pipeline advances. A good footer byte gives
// a result after the three stages of the float subtractors.
// The pipeline advances while the result register is empty or being taken;
// a held result stalls the byte input. csr writes are always taken.
// Reset clears the frame phase, the stage valids and both offsets.
module pose_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_yaw_bits,
   output logic [31:0] rsp_pos_x_bits,
   output logic [31:0] rsp_pos_y_bits,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   import pfp_pkg::*;

   logic        advance;
   frame_type   frame;
   logic [31:0] offset_x_ff, offset_y_ff;
   logic [2:0]  valid_ff, valid_in;
   logic [31:0] yaw1_ff, yaw2_ff, yaw3_ff;

   assign advance   = !valid_ff[2] || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   pfp_deframer u_deframer (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_valid && advance),
      .rx_byte (req_rx_byte),
      .frame   (frame)
   );

   pfp_fsub u_sub_x (
      .clock   (clock),
      .advance (advance),
      .a       (frame.x),
      .b       (offset_x_ff),
      .diff    (rsp_pos_x_bits)
   );

   pfp_fsub u_sub_y (
      .clock   (clock),
      .advance (advance),
      .a       (frame.y),
      .b       (offset_y_ff),
      .diff    (rsp_pos_y_bits)
   );

   assign valid_in = advance ? {valid_ff[1:0], frame.done} : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 3'd0;
         offset_x_ff <= 32'd0;
         offset_y_ff <= 32'd0;
      end else begin
         valid_ff <= valid_in;
         if (csr_valid && (csr_index == CSR_OFFSET_X)) offset_x_ff <= csr_data;
         if (csr_valid && (csr_index == CSR_OFFSET_Y)) offset_y_ff <= csr_data;
      end
   end

   // carry yaw alongside the subtractor stages
   always_ff @(posedge clock) begin
      if (advance) begin
         yaw1_ff <= frame.yaw;
         yaw2_ff <= yaw1_ff;
         yaw3_ff <= yaw2_ff;
      end
   end

   assign rsp_valid    = valid_ff[2];
   assign rsp_yaw_bits = yaw3_ff;

endmodule

@@ rtl/pfp_deframer.sv @@
// ----------------------------------------------------------------------------
// pfp_deframer
// Header hunt, payload collection and footer check, one byte per cycle while accept is high.
// ----------------------------------------------------------------------------
module pfp_deframer (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       rx_byte,
   output pfp_pkg::frame_type frame
);
   import pfp_pkg::*;

   logic [4:0]  phase_ff, phase_in;
   logic [31:0] yaw_ff, yaw_in, x_ff, x_in, y_ff, y_in;
   logic [4:0]  k;
   logic        in_payload;

   assign k = phase_ff - PH_PAY_FIRST;
   assign in_payload = (phase_ff >= PH_PAY_FIRST) && (phase_ff <= PH_PAY_LAST);

   function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] lane,
                                            input logic [7:0] b);
      logic [31:0] r;
      r = w;
      unique case (lane)
         2'd0: r[7:0]   = b;
         2'd1: r[15:8]  = b;
         2'd2: r[23:16] = b;
         2'd3: r[31:24] = b;
      endcase
      return r;
   endfunction

   always_comb begin
      phase_in = phase_ff;
      yaw_in   = yaw_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      if (accept) begin
         if (phase_ff == PH_HDR2) begin
            if (rx_byte == HDR_SECOND)     phase_in = PH_PAY_FIRST;
            else if (rx_byte == HDR_FIRST) phase_in = PH_HDR2;
            else                           phase_in = PH_HUNT;
         end else if (in_payload) begin
            if (k[4:2] == WORD_YAW) yaw_in = put_byte(yaw_ff, k[1:0], rx_byte);
            if (k[4:2] == WORD_X)   x_in   = put_byte(x_ff, k[1:0], rx_byte);
            if (k[4:2] == WORD_Y)   y_in   = put_byte(y_ff, k[1:0], rx_byte);
            phase_in = phase_ff + 5'd1;
         end else if (phase_ff == PH_FTR1) begin
            phase_in = (rx_byte == FTR_FIRST) ? PH_FTR2 : PH_HUNT;
         end else if (phase_ff == PH_FTR2) begin
            phase_in = PH_HUNT;
         end else begin
            phase_in = (rx_byte == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
         end
      end
   end

   assign frame.done = accept && (phase_ff == PH_FTR2) && (rx_byte == FTR_SECOND);
   assign frame.yaw  = yaw_ff;
   assign frame.x    = x_ff;
   assign frame.y    = y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      yaw_ff <= yaw_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

endmodule

@@ rtl/pfp_fsub.sv @@
// ----------------------------------------------------------------------------
// pfp_fsub
// Single-precision subtract a - b, round to nearest even, three stages.
// ----------------------------------------------------------------------------
module pfp_fsub (
   input  logic        clock,
   input  logic        advance,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] diff
);
   import pfp_pkg::*;

   // stage 1: specials, swap, align
   logic        sa, sbn, a_nan, b_nan, a_inf, b_inf, swap, xs, ys;
   logic [7:0]  ea, eb, xe_raw, ye_raw, ex, ey, d;
   logic [31:0] xb, yb, spec_val;
   logic [4:0]  dd;
   logic [26:0] y27, yal;

   logic        s1_special_ff, s1_sign_ff, s1_sub_ff, s1_zsign_ff;
   logic [31:0] s1_spec_ff;
   logic [7:0]  s1_exp_ff;
   logic [26:0] s1_mx_ff, s1_my_ff;

   assign sa  = a[31];
   assign sbn = ~b[31];
   assign ea  = a[30:23];
   assign eb  = b[30:23];
   assign a_nan = (ea == 8'hFF) && (a[22:0] != 23'd0);
   assign b_nan = (eb == 8'hFF) && (b[22:0] != 23'd0);
   assign a_inf = (ea == 8'hFF) && (a[22:0] == 23'd0);
   assign b_inf = (eb == 8'hFF) && (b[22:0] == 23'd0);

   always_comb begin
      priority if (a_nan)                          spec_val = a | 32'h0040_0000;
      else if (b_nan)                              spec_val = b | 32'h0040_0000;
      else if (a_inf && b_inf && (sa != sbn))      spec_val = 32'hFFC0_0000;
      else if (a_inf)                              spec_val = a;
      else                                         spec_val = {sbn, b[30:0]};
   end

   assign swap   = b[30:0] > a[30:0];
   assign xb     = swap ? b : a;
   assign yb     = swap ? a : b;
   assign xs     = swap ? sbn : sa;
   assign ys     = swap ? sa : sbn;
   assign xe_raw = xb[30:23];
   assign ye_raw = yb[30:23];
   assign ex     = (xe_raw == 8'd0) ? 8'd1 : xe_raw;
   assign ey     = (ye_raw == 8'd0) ? 8'd1 : ye_raw;
   assign d      = ex - ey;
   assign dd     = (d > 8'd27) ? 5'd27 : d[4:0];
   assign y27    = {(ye_raw != 8'd0), yb[22:0], 3'b000};
   assign yal    = (y27 >> dd) | {26'd0, |(y27 & ~(27'h7FF_FFFF << dd))};

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_special_ff <= (ea == 8'hFF) || (eb == 8'hFF);
         s1_spec_ff    <= spec_val;
         s1_sign_ff    <= xs;
         s1_sub_ff     <= xs != ys;
         s1_zsign_ff   <= sa & sbn;
         s1_exp_ff     <= ex;
         s1_mx_ff      <= {(xe_raw != 8'd0), xb[22:0], 3'b000};
         s1_my_ff      <= yal;
      end
   end

   // stage 2: add or subtract, count leading zeros
   logic [27:0] sum;
   logic        s2_special_ff, s2_sign_ff, s2_zsign_ff;
   logic [31:0] s2_spec_ff;
   logic [7:0]  s2_exp_ff;
   logic [27:0] s2_sum_ff;
   logic [4:0]  s2_lz_ff;

   assign sum = s1_sub_ff ? ({1'b0, s1_mx_ff} - {1'b0, s1_my_ff})
                          : ({1'b0, s1_mx_ff} + {1'b0, s1_my_ff});

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_special_ff <= s1_special_ff;
         s2_spec_ff    <= s1_spec_ff;
         s2_sign_ff    <= s1_sign_ff;
         s2_zsign_ff   <= s1_zsign_ff;
         s2_exp_ff     <= s1_exp_ff;
         s2_sum_ff     <= sum;
         s2_lz_ff      <= lzc27(sum[26:0]);
      end
   end

   // stage 3: normalise, round, pack
   logic [7:0]  lim, sh;
   logic [26:0] m27;
   logic [8:0]  e9, expf;
   logic [31:0] packed_w, rounded;
   logic        rup;
   logic [31:0] result;

   assign lim = s2_exp_ff - 8'd1;
   assign sh  = ({3'd0, s2_lz_ff} < lim) ? {3'd0, s2_lz_ff} : lim;

   always_comb begin
      if (s2_sum_ff[27]) begin
         m27 = {s2_sum_ff[27:2], s2_sum_ff[1] | s2_sum_ff[0]};
         e9  = {1'b0, s2_exp_ff} + 9'd1;
      end else begin
         m27 = s2_sum_ff[26:0] << sh;
         e9  = {1'b0, s2_exp_ff} - {1'b0, sh};
      end
      expf     = m27[26] ? e9 : 9'd0;
      packed_w = {expf, m27[25:3]};
      rup      = m27[2] & ((|m27[1:0]) | m27[3]);
      rounded  = packed_w + {31'd0, rup};
      if (s2_special_ff)              result = s2_spec_ff;
      else if (s2_sum_ff == 28'd0)    result = {s2_zsign_ff, 31'd0};
      else if (rounded[31:23] >= 9'd255) result = {s2_sign_ff, 8'hFF, 23'd0};
      else                            result = {s2_sign_ff, rounded[30:0]};
   end

   logic [31:0] s3_ff;
   always_ff @(posedge clock) begin
      if (advance) s3_ff <= result;
   end
   assign diff = s3_ff;

endmodule

@@ rtl/pfp_checker.sv @@
// ----------------------------------------------------------------------------
// pfp_checker
// Port-level checks on the pose frame parser.
// ----------------------------------------------------------------------------
`include "pose_frame_parser_assert.svh"

module pfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_yaw_bits,
   input logic        csr_valid,
   input logic        csr_ready
);

   // a held result holds its item
   `PFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_yaw_bits))
   // a held result stalls the byte input
   `PFP_ASSERT_NOW(a_stall, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   // csr writes are never refused
   `PFP_ASSERT_NOW(a_csr, clock, reset, csr_valid, csr_ready)
   // no result straight after reset
   `PFP_ASSERT_NEXT(a_rst, clock, 1'b0, reset, !rsp_valid)

endmodule

bind pose_frame_parser pfp_checker u_pfp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_yaw_bits (rsp_yaw_bits),
   .csr_valid    (csr_valid),
   .csr_ready    (csr_ready)
);
